[design/ndwi_pkg.sv]
// ----------------------------------------------------------------------------
// ndwi_pkg
// shared constants, register indexes and the sideband type of the ndwi pipe
// ----------------------------------------------------------------------------
package ndwi_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FIELD_BITS      = 16;
	localparam int Q_FRAC          = 15;
	localparam int QUOT_BITS       = 16;
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 16;
	localparam int OFFSET_BITS     = 15;

	localparam logic [CFG_IDX_BITS-1:0] REG_WATER_THR = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_VEG_THR   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SEA_OFS   = 2'd2;

	localparam logic signed [15:0] WATER_THR_RST = 16'sd0;
	localparam logic signed [15:0] VEG_THR_RST   = -16'sd11469;
	localparam logic [OFFSET_BITS-1:0] SEA_OFS_RST = 15'd3277;

	localparam logic signed [15:0] Q15_MAX = 16'sh7fff;

	typedef struct packed {
		logic last;
		logic neg;
		logic zero;
		logic ndvi_hit;
	} tag_t;

endpackage

[design/ndwi_water_index_pixel.sv]
// ----------------------------------------------------------------------------
// ndwi_water_index_pixel
// per-pixel ndwi in q1.15 with ndvi-gated sea override, pipelined divider
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  green, nir, red samples, end_of_image
//   out      source     out_valid/out_stall  index_value, flags, last_pixel
//   cfg      sink       cfg_wr_en            cfg_index, cfg_data
//
// one pixel per cycle while not stalled: 2 front stages, one cell per
// quotient bit (16), one output register
// the whole pipe advances together; it holds while a result waits under out_stall
// reset clears valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module ndwi_water_index_pixel #(
	parameter int SAMPLE_BITS = ndwi_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [ndwi_pkg::FIELD_BITS-1:0]        green_sample,
	input  logic [ndwi_pkg::FIELD_BITS-1:0]        nir_sample,
	input  logic [ndwi_pkg::FIELD_BITS-1:0]        red_sample,
	input  logic                                   end_of_image,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [15:0]                     index_value,
	output logic                                   sea_flag,
	output logic                                   zero_sum_flag,
	output logic                                   last_pixel,
	input  logic                                   cfg_wr_en,
	input  logic [ndwi_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [ndwi_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int SB = SAMPLE_BITS;
	localparam int QB = ndwi_pkg::QUOT_BITS;

	logic signed [15:0]                   water_thr_q, veg_thr_q;
	logic [ndwi_pkg::OFFSET_BITS-1:0]     sea_ofs_q;
	logic                                 en;

	logic                 chain_valid [0:QB];
	logic [SB+1:0]        chain_rem   [0:QB];
	logic [SB:0]          chain_den   [0:QB];
	logic [QB-1:0]        chain_quot  [0:QB];
	ndwi_pkg::tag_t       chain_tag   [0:QB];
	logic [SB-1:0]        front_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_thr_q <= ndwi_pkg::WATER_THR_RST;
			veg_thr_q   <= ndwi_pkg::VEG_THR_RST;
			sea_ofs_q   <= ndwi_pkg::SEA_OFS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ndwi_pkg::REG_WATER_THR: water_thr_q <= cfg_data;
				ndwi_pkg::REG_VEG_THR:   veg_thr_q   <= cfg_data;
				ndwi_pkg::REG_SEA_OFS:   sea_ofs_q   <= cfg_data[ndwi_pkg::OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	ndwi_front #(.SAMPLE_BITS(SB)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.up_valid     (in_valid),
		.green_sample (green_sample),
		.nir_sample   (nir_sample),
		.red_sample   (red_sample),
		.end_of_image (end_of_image),
		.veg_thr      (veg_thr_q),
		.dn_valid     (chain_valid[0]),
		.dn_den       (chain_den[0]),
		.dn_mag       (front_mag),
		.dn_tag       (chain_tag[0])
	);

	assign chain_rem[0]  = {2'b00, front_mag};
	assign chain_quot[0] = '0;

	for (genvar i = 0; i < QB; i++) begin : g_cell
		ndwi_cell #(.SAMPLE_BITS(SB)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (chain_valid[i]),
			.up_rem   (chain_rem[i]),
			.up_den   (chain_den[i]),
			.up_quot  (chain_quot[i]),
			.up_tag   (chain_tag[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_rem   (chain_rem[i+1]),
			.dn_den   (chain_den[i+1]),
			.dn_quot  (chain_quot[i+1]),
			.dn_tag   (chain_tag[i+1])
		);
	end

	ndwi_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.up_valid      (chain_valid[QB]),
		.up_quot       (chain_quot[QB]),
		.up_tag        (chain_tag[QB]),
		.water_thr     (water_thr_q),
		.sea_ofs       (sea_ofs_q),
		.dn_valid      (out_valid),
		.index_value   (index_value),
		.sea_flag      (sea_flag),
		.zero_sum_flag (zero_sum_flag),
		.last_pixel    (last_pixel)
	);

`ifndef SYNTHESIS
	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_sum_flag |-> index_value == '0 && !sea_flag)
		else $error("zero sum result not cleared");

	a_sea_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sea_flag |-> index_value >= water_thr_q)
		else $error("sea value below water threshold");

	a_sea_last_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[QB] && !chain_tag[QB].zero |-> chain_rem[QB] < {chain_den[QB], 1'b0})
		else $error("divider remainder out of range");
`endif

endmodule

[design/ndwi_front.sv]
// ----------------------------------------------------------------------------
// ndwi_front
// two input stages: sums, difference magnitude and the ndvi cross compare
// ----------------------------------------------------------------------------
module ndwi_front #(
	parameter int SAMPLE_BITS = ndwi_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                up_valid,
	input  logic [ndwi_pkg::FIELD_BITS-1:0]     green_sample,
	input  logic [ndwi_pkg::FIELD_BITS-1:0]     nir_sample,
	input  logic [ndwi_pkg::FIELD_BITS-1:0]     red_sample,
	input  logic                                end_of_image,
	input  logic signed [15:0]                  veg_thr,
	output logic                                dn_valid,
	output logic [SAMPLE_BITS:0]                dn_den,
	output logic [SAMPLE_BITS-1:0]              dn_mag,
	output ndwi_pkg::tag_t                      dn_tag
);

	localparam int SB = SAMPLE_BITS;
	localparam int PW = SB + 18;

	logic [SB-1:0]          g, n, r;
	logic [SB:0]            den_c, vsum_c;
	logic                   neg_c;
	logic [SB-1:0]          mag_c;
	logic signed [SB:0]     vdiff_c;
	logic signed [PW-1:0]   lhs_c, prod_c;

	logic                   valid_s1;
	logic [SB:0]            den_s1;
	logic [SB-1:0]          mag_s1;
	logic                   neg_s1, zero_s1, last_s1, vzero_s1;
	logic signed [PW-1:0]   lhs_s1, prod_s1;

	logic                   valid_s2;
	logic [SB:0]            den_s2;
	logic [SB-1:0]          mag_s2;
	ndwi_pkg::tag_t         tag_s2;

	assign g = green_sample[SB-1:0];
	assign n = nir_sample[SB-1:0];
	assign r = red_sample[SB-1:0];

	assign den_c   = {1'b0, g} + {1'b0, n};
	assign vsum_c  = {1'b0, n} + {1'b0, r};
	assign neg_c   = n > g;
	assign mag_c   = neg_c ? (n - g) : (g - n);
	assign vdiff_c = $signed({1'b0, n}) - $signed({1'b0, r});
	assign lhs_c   = PW'(vdiff_c) <<< ndwi_pkg::Q_FRAC;
	assign prod_c  = PW'(veg_thr) * PW'($signed({1'b0, vsum_c}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s1   <= den_c;
			mag_s1   <= mag_c;
			neg_s1   <= neg_c;
			zero_s1  <= den_c == '0;
			last_s1  <= end_of_image;
			vzero_s1 <= vsum_c == '0;
			lhs_s1   <= lhs_c;
			prod_s1  <= prod_c;

			den_s2          <= den_s1;
			mag_s2          <= mag_s1;
			tag_s2.last     <= last_s1;
			tag_s2.neg      <= neg_s1;
			tag_s2.zero     <= zero_s1;
			tag_s2.ndvi_hit <= !vzero_s1 && (lhs_s1 < prod_s1);
		end
	end

	assign dn_valid = valid_s2;
	assign dn_den   = den_s2;
	assign dn_mag   = mag_s2;
	assign dn_tag   = tag_s2;

endmodule

[design/ndwi_cell.sv]
// ----------------------------------------------------------------------------
// ndwi_cell
// one restoring division step: resolves one quotient bit per cell
// ----------------------------------------------------------------------------
module ndwi_cell #(
	parameter int SAMPLE_BITS = ndwi_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                up_valid,
	input  logic [SAMPLE_BITS+1:0]              up_rem,
	input  logic [SAMPLE_BITS:0]                up_den,
	input  logic [ndwi_pkg::QUOT_BITS-1:0]      up_quot,
	input  ndwi_pkg::tag_t                      up_tag,
	output logic                                dn_valid,
	output logic [SAMPLE_BITS+1:0]              dn_rem,
	output logic [SAMPLE_BITS:0]                dn_den,
	output logic [ndwi_pkg::QUOT_BITS-1:0]      dn_quot,
	output ndwi_pkg::tag_t                      dn_tag
);

	localparam int SB = SAMPLE_BITS;
	localparam int QB = ndwi_pkg::QUOT_BITS;

	logic              ge_c;
	logic [SB+1:0]     diff_c, next_c;

	logic              valid_q;
	logic [SB+1:0]     rem_q;
	logic [SB:0]       den_q;
	logic [QB-1:0]     quot_q;
	ndwi_pkg::tag_t    tag_q;

	assign ge_c   = up_rem >= {1'b0, up_den};
	assign diff_c = up_rem - {1'b0, up_den};
	assign next_c = ge_c ? diff_c : up_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= {next_c[SB:0], 1'b0};
			den_q  <= up_den;
			quot_q <= {up_quot[QB-2:0], ge_c};
			tag_q  <= up_tag;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rem   = rem_q;
	assign dn_den   = den_q;
	assign dn_quot  = quot_q;
	assign dn_tag   = tag_q;

endmodule

[design/ndwi_back.sv]
// ----------------------------------------------------------------------------
// ndwi_back
// sign and saturation of the quotient, sea override, output register
// ----------------------------------------------------------------------------
module ndwi_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  up_valid,
	input  logic [ndwi_pkg::QUOT_BITS-1:0]        up_quot,
	input  ndwi_pkg::tag_t                        up_tag,
	input  logic signed [15:0]                    water_thr,
	input  logic [ndwi_pkg::OFFSET_BITS-1:0]      sea_ofs,
	output logic                                  dn_valid,
	output logic signed [15:0]                    index_value,
	output logic                                  sea_flag,
	output logic                                  zero_sum_flag,
	output logic                                  last_pixel
);

	localparam int QB = ndwi_pkg::QUOT_BITS;

	logic signed [QB:0]   qext_c, sval_c;
	logic signed [15:0]   ndwi_c, forced_sat_c, index_c;
	logic signed [16:0]   forced_c;
	logic                 sea_c;

	logic                 valid_q;
	logic signed [15:0]   index_q;
	logic                 sea_q, zero_q, last_q;

	assign qext_c = $signed({1'b0, up_quot});
	assign sval_c = up_tag.neg ? -qext_c : qext_c;
	// only a positive full-scale quotient overflows
	assign ndwi_c = (!up_tag.neg && up_quot[QB-1]) ? ndwi_pkg::Q15_MAX : sval_c[15:0];

	assign forced_c     = 17'(water_thr) + $signed({2'b00, sea_ofs});
	assign forced_sat_c = (!forced_c[16] && forced_c[15]) ? ndwi_pkg::Q15_MAX
							: forced_c[15:0];

	assign sea_c = !up_tag.zero && up_tag.ndvi_hit && (ndwi_c > water_thr);

	always_comb begin
		index_c = ndwi_c;
		if (up_tag.zero) begin
			index_c = '0;
		end else if (sea_c) begin
			index_c = forced_sat_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			index_q <= index_c;
			sea_q   <= sea_c;
			zero_q  <= up_tag.zero;
			last_q  <= up_tag.last;
		end
	end

	assign dn_valid      = valid_q;
	assign index_value   = index_q;
	assign sea_flag      = sea_q;
	assign zero_sum_flag = zero_q;
	assign last_pixel    = last_q;

endmodule
